FILE: rtl/mst_pkg.sv
// Shared types for the membership set table: operation codes, sweep states, cell command.
package mst_pkg;

  // operation carried by each input word
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic  active;   // a sweep is running this cycle
    mode_t mode;     // operation of the word in flight
    logic  found;    // a match was seen in an earlier cell
    logic  clear;    // drop every entry at this edge
  } cell_cmd_t;

endpackage

FILE: rtl/mst_cell.sv
// One storage cell of the set chain: holds one entry, compares it, shifts from its upper neighbor.
module mst_cell
  import mst_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic                     sel,        // sweep is at this cell
  input  logic [ELEMENT_WIDTH-1:0] value,
  input  logic [ELEMENT_WIDTH-1:0] nbr_entry,  // entry of the next cell up
  input  logic                     nbr_valid,
  output logic [ELEMENT_WIDTH-1:0] entry,
  output logic                     valid,
  output logic                     match
);

  logic [ELEMENT_WIDTH-1:0] entry_r, entry_nxt;
  logic                     valid_r, valid_nxt;

  assign match = valid_r && (entry_r == value);
  assign entry = entry_r;
  assign valid = valid_r;

  // local update when the sweep passes this cell
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd.clear) begin
      valid_nxt = 1'b0;
    end else if (cmd.active && sel) begin
      case (cmd.mode)
        MODE_ADD: begin
          // first free cell after the occupied run takes an absent value
          if (!cmd.found && !valid_r) begin
            entry_nxt = value;
            valid_nxt = 1'b1;
          end
        end
        MODE_REMOVE: begin
          // at and above the match, pull the upper neighbor down
          if ((cmd.found || match) && valid_r) begin
            entry_nxt = nbr_entry;
            valid_nxt = nbr_valid;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: rtl/membership_set_table_unit.sv
// Membership set table: a compacted set of distinct values held in a chain of cells, swept per word.
//
// A word is taken when start is high and busy is low. The controller then sweeps the cell
// chain one cell per cycle from the bottom, stopping at the first free cell or at the top
// cell. The result appears on out_valid for one cycle right after the sweep, and busy is
// already low in that cycle, so a new word may be started then. The sweep length is set by
// the chain walk, one cell compare and shift per clock. Results cannot be held off; the
// receiver must take each one in its strobe cycle.
module membership_set_table_unit
  import mst_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_element,
  output logic        out_valid,
  output logic        out_was_present,
  output logic [4:0]  out_element_count,
  output logic        out_full_drop
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  state_t                   state_r, state_nxt;
  mode_t                    mode_r, mode_nxt;
  logic [ELEMENT_WIDTH-1:0] value_r, value_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic                     found_r, found_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     present_r, present_nxt;
  logic                     drop_r, drop_nxt;

  logic [ELEMENT_WIDTH+31:0] elem_ext;
  logic [CW+4:0]             cnt_ext;
  logic                      accept, cur_valid, cur_match, found_now, done;
  cell_cmd_t                 cmd;

  logic [ELEMENT_WIDTH-1:0] entry_arr [CAPACITY];
  logic [CAPACITY-1:0]      valid_vec;
  logic [CAPACITY-1:0]      match_vec;

  assign accept   = start && !busy;
  assign busy     = (state_r == ST_SWEEP);
  assign elem_ext = {{ELEMENT_WIDTH{1'b0}}, in_element};

  // cell under the sweep
  assign cur_valid = valid_vec[pos_r];
  assign cur_match = match_vec[pos_r];
  assign found_now = found_r || cur_match;
  assign done      = busy && (!cur_valid || (pos_r == LAST_POS));

  // broadcast command
  always_comb begin
    cmd.active = busy;
    cmd.mode   = mode_r;
    cmd.found  = found_r;
    cmd.clear  = done && (mode_r == MODE_CLEAR);
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] nbr_entry;
    logic                     nbr_valid;
    if (i < CAPACITY - 1) begin : g_mid
      assign nbr_entry = entry_arr[i+1];
      assign nbr_valid = valid_vec[i+1];
    end else begin : g_top
      assign nbr_entry = '0;
      assign nbr_valid = 1'b0;
    end
    mst_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (pos_r == PW'(i)),
      .value    (value_r),
      .nbr_entry(nbr_entry),
      .nbr_valid(nbr_valid),
      .entry    (entry_arr[i]),
      .valid    (valid_vec[i]),
      .match    (match_vec[i])
    );
  end

  // sweep control, count update and result
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    value_nxt     = value_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    present_nxt   = present_r;
    drop_nxt      = drop_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SWEEP;
          mode_nxt  = mode_t'(in_mode);
          value_nxt = elem_ext[ELEMENT_WIDTH-1:0];
          pos_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SWEEP: begin
        found_nxt = found_now;
        pos_nxt   = pos_r + PW'(1);
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          present_nxt   = found_now;
          drop_nxt      = 1'b0;
          case (mode_r)
            MODE_ADD: begin
              if (!found_now) begin
                if (!cur_valid) begin
                  occ_nxt = occ_r + CW'(1);
                end else begin
                  drop_nxt = 1'b1;
                end
              end
            end
            MODE_REMOVE: begin
              if (found_now) begin
                occ_nxt = occ_r - CW'(1);
              end
            end
            MODE_CLEAR: begin
              occ_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // word in flight and result payload
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    value_r   <= value_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
    present_r <= present_nxt;
    drop_r    <= drop_nxt;
  end

  assign cnt_ext           = {5'b0, occ_r};
  assign out_valid         = out_valid_r;
  assign out_was_present   = present_r;
  assign out_element_count = cnt_ext[4:0];
  assign out_full_drop     = drop_r;

`ifndef SYNTHESIS
  // count never passes the capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CAP_CNT)
    else $error("occupancy above capacity");

  // an accepted word always starts a sweep
  a_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not start a sweep");

  // result strobe comes only after the sweep ends
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside sweep end");

  // a drop only happens with the set full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_drop) |-> (occ_r == CAP_CNT))
    else $error("drop reported with room left");
`endif

endmodule
